// ===== hdl/cmdack_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdack_pkg
// Shared types and constants for the command parser with acknowledged
// ADC reporting: reply job layout, character codes and reset values.
// ----------------------------------------------------------------------------
package cmdack_pkg;

   // Default command buffer capacity and reply job queue depth.
   localparam int CMD_CAPACITY_DEF = 16;
   localparam int QUEUE_DEPTH      = 4;

   // Number of command characters kept for matching.
   localparam int KEPT_CHARS = 3;

   // Timer register widths and reset values.
   localparam int         TICK_W          = 9;
   localparam logic [8:0] FIRST_DELAY_RST = 9'd1;
   localparam logic [8:0] RESEND_RST      = 9'd300;

   // Sample scaling: hundredths of a volt = (sample * 500) >> 12.
   localparam int          HUND_W    = 9;
   localparam logic [20:0] ADC_SCALE = 21'd500;

   // Configuration register indexes.
   localparam logic CSR_FIRST_DELAY = 1'b0;
   localparam logic CSR_RESEND      = 1'b1;

   // Input operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Framing and command characters.
   localparam logic [7:0] CHAR_BANG = 8'h21;   // '!'
   localparam logic [7:0] CHAR_HASH = 8'h23;   // '#'
   localparam logic [7:0] CHAR_R    = 8'h52;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_T    = 8'h54;
   localparam logic [7:0] CHAR_O    = 8'h4F;
   localparam logic [7:0] CHAR_K    = 8'h4B;

   // Index of the last character of each reply.
   localparam logic [3:0] REPORT_LAST_IDX = 4'd11;
   localparam logic [3:0] STOP_LAST_IDX   = 4'd6;

   typedef enum logic {
      JOB_REPORT,
      JOB_STOP
   } job_kind_type;

   // One reply to be sent by the back end.
   typedef struct packed {
      job_kind_type       kind;
      logic [HUND_W-1:0]  hundredths;
   } job_type;

endpackage : cmdack_pkg
`default_nettype wire

// ===== hdl/cmdack_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdack_front
// Accepts received bytes and timer ticks, parses framed commands, runs the
// report timer and queues one reply job for every reply that must be sent.
// ----------------------------------------------------------------------------
module cmdack_front #(
   parameter int CMD_CAPACITY = cmdack_pkg::CMD_CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_op,
   input  wire logic [7:0]                  req_rx_byte,
   input  wire logic [11:0]                 req_adc_sample,
   input  wire logic [cmdack_pkg::TICK_W-1:0] first_delay,
   input  wire logic [cmdack_pkg::TICK_W-1:0] resend_period,
   input  wire logic                        queue_full,
   output logic                             job_valid,
   output cmdack_pkg::job_type              job
);
   import cmdack_pkg::*;

   localparam int CNT_W = $clog2(CMD_CAPACITY + 1);

   logic                 in_frame_ff, in_frame_in;
   logic [7:0]           chars_ff [KEPT_CHARS];
   logic [7:0]           chars_in [KEPT_CHARS];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 reporting_ff, reporting_in;
   logic                 locked_ff, locked_in;
   logic [HUND_W-1:0]    held_ff, held_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic                 pending_ff, pending_in;

   logic                 accept;
   logic                 rst_match;
   logic                 ok_match;
   logic [20:0]          scaled;

   // A transaction is taken whenever the reply queue has room.
   assign req_ready = ~queue_full;
   assign accept    = req_valid & req_ready;

   // Command matches need enough characters from this frame.
   assign rst_match = (count_ff >= CNT_W'(3)) && (chars_ff[0] == CHAR_R)
                      && (chars_ff[1] == CHAR_S) && (chars_ff[2] == CHAR_T);
   assign ok_match  = (count_ff >= CNT_W'(2)) && (chars_ff[0] == CHAR_O)
                      && (chars_ff[1] == CHAR_K);

   assign scaled = 21'(req_adc_sample) * ADC_SCALE;

   // Parser and timer next state.
   always_comb begin
      in_frame_in  = in_frame_ff;
      chars_in     = chars_ff;
      count_in     = count_ff;
      reporting_in = reporting_ff;
      locked_in    = locked_ff;
      held_in      = held_ff;
      tick_in      = tick_ff;
      pending_in   = pending_ff;
      job_valid    = 1'b0;
      job.kind     = JOB_REPORT;
      job.hundredths = held_ff;

      if (accept) begin
         if (req_op == OP_TICK) begin
            if (tick_ff != '0) begin
               tick_in = tick_ff - TICK_W'(1);
               if (tick_ff == TICK_W'(1)) begin
                  pending_in = 1'b1;
               end
            end
            if (reporting_ff && pending_in) begin
               job_valid  = 1'b1;
               tick_in    = resend_period;
               pending_in = 1'b0;
            end
         end else if (!in_frame_ff) begin
            if (req_rx_byte == CHAR_BANG) begin
               in_frame_in = 1'b1;
               count_in    = '0;
            end
         end else if (req_rx_byte == CHAR_BANG) begin
            // A start mark inside a frame is ignored.
         end else if (req_rx_byte != CHAR_HASH) begin
            if (count_ff < CNT_W'(CMD_CAPACITY)) begin
               if (count_ff < CNT_W'(KEPT_CHARS)) begin
                  chars_in[count_ff[1:0]] = req_rx_byte;
               end
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            in_frame_in = 1'b0;
            if (rst_match) begin
               if (!locked_ff) begin
                  held_in   = scaled[20:12];
                  locked_in = 1'b1;
               end
               reporting_in = 1'b1;
               tick_in      = first_delay;
               pending_in   = 1'b0;
            end else if (ok_match) begin
               locked_in    = 1'b0;
               reporting_in = 1'b0;
               tick_in      = '0;
               pending_in   = 1'b0;
               job_valid    = 1'b1;
               job.kind     = JOB_STOP;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         reporting_ff <= 1'b0;
         locked_ff    <= 1'b0;
         held_ff      <= '0;
         tick_ff      <= '0;
         pending_ff   <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         reporting_ff <= reporting_in;
         locked_ff    <= locked_in;
         held_ff      <= held_in;
         tick_ff      <= tick_in;
         pending_ff   <= pending_in;
      end
   end

   // Kept command characters carry no reset.
   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

endmodule : cmdack_front
`default_nettype wire

// ===== hdl/cmdack_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdack_queue
// Small FIFO of reply jobs between the parser front end and the serializer.
// ----------------------------------------------------------------------------
module cmdack_queue #(
   parameter int DEPTH = cmdack_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cmdack_pkg::job_type push_job,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output cmdack_pkg::job_type      head_job
);
   import cmdack_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule : cmdack_queue
`default_nettype wire

// ===== hdl/cmdack_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmdack_back
// Serializes queued reply jobs into characters, one character per
// transaction, marking the final character of each reply.
// ----------------------------------------------------------------------------
module cmdack_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire cmdack_pkg::job_type head_job,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_last
);
   import cmdack_pkg::*;

   logic                active_ff, active_in;
   job_kind_type        kind_ff, kind_in;
   logic [HUND_W-1:0]   hund_ff, hund_in;
   logic [3:0]          idx_ff, idx_in;

   logic                fire;
   logic [3:0]          units;
   logic [6:0]          frac;
   logic [14:0]         tens_prod;
   logic [3:0]          tens;
   logic [3:0]          ones;

   assign rsp_valid = active_ff;
   assign fire      = rsp_valid & rsp_ready;
   assign rsp_last  = (kind_ff == JOB_STOP) ? (idx_ff == STOP_LAST_IDX)
                                            : (idx_ff == REPORT_LAST_IDX);
   assign pop       = head_valid & (~active_ff | (fire & rsp_last));

   // Decimal digits of the held value (0 to 4.99).
   always_comb begin
      priority if (hund_ff >= HUND_W'(400)) begin
         units = 4'd4;
      end else if (hund_ff >= HUND_W'(300)) begin
         units = 4'd3;
      end else if (hund_ff >= HUND_W'(200)) begin
         units = 4'd2;
      end else if (hund_ff >= HUND_W'(100)) begin
         units = 4'd1;
      end else begin
         units = 4'd0;
      end
   end

   assign frac      = 7'(hund_ff - HUND_W'(units) * HUND_W'(100));
   assign tens_prod = 15'(frac) * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 4'(frac - 7'(tens) * 7'd10);

   // Character select for the current position of the reply.
   always_comb begin
      rsp_tx_byte = 8'h00;
      unique case (kind_ff)
         JOB_REPORT: begin
            case (idx_ff)
               4'd0:    rsp_tx_byte = 8'h21;            // '!'
               4'd1:    rsp_tx_byte = 8'h41;            // 'A'
               4'd2:    rsp_tx_byte = 8'h44;            // 'D'
               4'd3:    rsp_tx_byte = 8'h43;            // 'C'
               4'd4:    rsp_tx_byte = 8'h3D;            // '='
               4'd5:    rsp_tx_byte = 8'h30 + 8'(units);
               4'd6:    rsp_tx_byte = 8'h2E;            // '.'
               4'd7:    rsp_tx_byte = 8'h30 + 8'(tens);
               4'd8:    rsp_tx_byte = 8'h30 + 8'(ones);
               4'd9:    rsp_tx_byte = 8'h23;            // '#'
               4'd10:   rsp_tx_byte = 8'h0D;
               default: rsp_tx_byte = 8'h0A;
            endcase
         end
         JOB_STOP: begin
            case (idx_ff)
               4'd0:    rsp_tx_byte = 8'h53;            // 'S'
               4'd1:    rsp_tx_byte = 8'h54;            // 'T'
               4'd2:    rsp_tx_byte = 8'h4F;            // 'O'
               4'd3:    rsp_tx_byte = 8'h50;            // 'P'
               4'd4:    rsp_tx_byte = 8'h23;            // '#'
               4'd5:    rsp_tx_byte = 8'h0D;
               default: rsp_tx_byte = 8'h0A;
            endcase
         end
         default: rsp_tx_byte = 8'h00;
      endcase
   end

   // Load a new job when idle or right after the final character goes out.
   always_comb begin
      active_in = active_ff;
      kind_in   = kind_ff;
      hund_in   = hund_ff;
      idx_in    = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         kind_in   = head_job.kind;
         hund_in   = head_job.hundredths;
         idx_in    = '0;
      end else if (fire) begin
         if (rsp_last) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   // Job payload carries no reset.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      hund_ff <= hund_in;
   end

endmodule : cmdack_back
`default_nettype wire

// ===== hdl/command_ack_adc_reporter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_ack_adc_reporter_top
// Framed command parser that latches an ADC reading on RST if none is held,
// sends periodic "!ADC=d.dd#" reports on timer expiry, answers OK with "STOP#".
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake         Payload
//   req_      in         valid / ready     op, rx_byte, adc_sample
//   rsp_      out        valid / ready     tx_byte, last
//   csr_      in/out     APB, pready = 1   first delay (0x0), resend period (0x4)
//
// The front end takes one transaction per cycle while the reply queue has
// room; parsing and the timer update in that same cycle.
// Replies go out one character per cycle while rsp_ready is high; a report has
// 12 characters, STOP 7, so the serializer sets the sustained rate when replying.
// Reset is synchronous and active high; it needs no clearing pass.
// Output stalls back up into the queue and only then hold off req_ready.
// ----------------------------------------------------------------------------
module command_ack_adc_reporter_top #(
   parameter int CMD_CAPACITY = cmdack_pkg::CMD_CAPACITY_DEF,
   parameter int QUEUE_DEPTH  = cmdack_pkg::QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_op,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic [11:0]  req_adc_sample,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import cmdack_pkg::*;

   logic [TICK_W-1:0] first_delay_ff, first_delay_in;
   logic [TICK_W-1:0] resend_ff, resend_in;
   logic              csr_write;

   logic              job_valid;
   job_type           job;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   job_type           head_job;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      first_delay_in = first_delay_ff;
      resend_in      = resend_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_FIRST_DELAY: first_delay_in = csr_pwdata[TICK_W-1:0];
            CSR_RESEND:      resend_in      = csr_pwdata[TICK_W-1:0];
            default:         first_delay_in = first_delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= FIRST_DELAY_RST;
         resend_ff      <= RESEND_RST;
      end else begin
         first_delay_ff <= first_delay_in;
         resend_ff      <= resend_in;
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_paddr[2])
         CSR_FIRST_DELAY: csr_prdata = 32'(first_delay_ff);
         CSR_RESEND:      csr_prdata = 32'(resend_ff);
         default:         csr_prdata = '0;
      endcase
   end

   cmdack_front #(
      .CMD_CAPACITY (CMD_CAPACITY)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_rx_byte    (req_rx_byte),
      .req_adc_sample (req_adc_sample),
      .first_delay    (first_delay_ff),
      .resend_period  (resend_ff),
      .queue_full     (queue_full),
      .job_valid      (job_valid),
      .job            (job)
   );

   cmdack_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cmdack_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule : command_ack_adc_reporter_top
`default_nettype wire
